/* rtl/ffkv_pkg.sv */
// shared constants and types for the fifo-replacement key/value cache
package ffkv_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_WIDTH  = 64;
  localparam int DEF_DATA_WIDTH = 64;

  localparam int KEY_PORT_W  = 64;
  localparam int DATA_PORT_W = 64;
  localparam int CAP_W       = 5;
  localparam int ADDR_W      = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // request codes
  localparam logic [1:0] REQ_GET    = 2'd0;
  localparam logic [1:0] REQ_PUT    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // register word index (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  // flags that travel along the cell chain with a probe
  typedef struct packed {
    logic active;
    logic found;
    logic ev_have;
    logic ev_ge;
    logic fr_have;
    logic fr_ge;
  } probe_flags_t;

  // update command broadcast to all cells at commit
  typedef struct packed {
    logic clear;
    logic inv;
    logic wr;
    logic wr_key;
  } cell_cmd_t;

endpackage

/* rtl/ffkv_cell.sv */
// one cache entry plus its stage of the probe chain
module ffkv_cell #(
  parameter int ENTRIES    = ffkv_pkg::DEF_ENTRIES,
  parameter int KEY_WIDTH  = ffkv_pkg::DEF_KEY_WIDTH,
  parameter int DATA_WIDTH = ffkv_pkg::DEF_DATA_WIDTH,
  parameter int CELL_ID    = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [KEY_WIDTH-1:0]          req_key,
  input  logic [DATA_WIDTH-1:0]         wr_data,
  input  logic [$clog2(ENTRIES)-1:0]    evict_ptr,
  input  logic [$clog2(ENTRIES)-1:0]    insert_ptr,
  input  ffkv_pkg::cell_cmd_t           cmd,
  input  logic [$clog2(ENTRIES)-1:0]    wr_idx,
  input  logic [$clog2(ENTRIES)-1:0]    inv_idx,
  input  ffkv_pkg::probe_flags_t        prev_flags,
  input  logic [$clog2(ENTRIES)-1:0]    prev_found_idx,
  input  logic [DATA_WIDTH-1:0]         prev_data,
  input  logic [$clog2(ENTRIES)-1:0]    prev_ev_idx,
  input  logic [$clog2(ENTRIES)-1:0]    prev_fr_idx,
  output ffkv_pkg::probe_flags_t        fwd_flags,
  output logic [$clog2(ENTRIES)-1:0]    fwd_found_idx,
  output logic [DATA_WIDTH-1:0]         fwd_data,
  output logic [$clog2(ENTRIES)-1:0]    fwd_ev_idx,
  output logic [$clog2(ENTRIES)-1:0]    fwd_fr_idx
);
  import ffkv_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

  logic                  valid;
  logic [KEY_WIDTH-1:0]  stored_key;
  logic [DATA_WIDTH-1:0] stored_value;

  logic match;
  logic ge_ep;
  logic ge_ip;
  logic ev_take;
  logic fr_take;

  assign match = valid && (stored_key == req_key);
  assign ge_ep = MY_IDX >= evict_ptr;
  assign ge_ip = MY_IDX >= insert_ptr;
  // keep the first candidate at or after the pointer, else the first overall
  assign ev_take = valid && (!prev_flags.ev_have || (!prev_flags.ev_ge && ge_ep));
  assign fr_take = !valid && (!prev_flags.fr_have || (!prev_flags.fr_ge && ge_ip));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      fwd_flags <= '0;
    end else begin
      fwd_flags.active  <= prev_flags.active;
      fwd_flags.found   <= prev_flags.found | match;
      fwd_flags.ev_have <= prev_flags.ev_have | ev_take;
      fwd_flags.ev_ge   <= ev_take ? ge_ep : prev_flags.ev_ge;
      fwd_flags.fr_have <= prev_flags.fr_have | fr_take;
      fwd_flags.fr_ge   <= fr_take ? ge_ip : prev_flags.fr_ge;
      if (cmd.clear) begin
        valid <= 1'b0;
      end else if (cmd.wr_key && (wr_idx == MY_IDX)) begin
        valid <= 1'b1;
      end else if (cmd.inv && (inv_idx == MY_IDX)) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_found_idx <= match ? MY_IDX : prev_found_idx;
    fwd_data      <= match ? stored_value : prev_data;
    fwd_ev_idx    <= ev_take ? MY_IDX : prev_ev_idx;
    fwd_fr_idx    <= fr_take ? MY_IDX : prev_fr_idx;
    if (cmd.wr && (wr_idx == MY_IDX)) begin
      stored_value <= wr_data;
    end
    if (cmd.wr_key && (wr_idx == MY_IDX)) begin
      stored_key <= req_key;
    end
  end

endmodule

/* rtl/fifo_replacement_key_value_cache.sv */
// top level: fully associative key/value cache with fifo replacement
//
//   channel  | signals                                    | direction
//   ---------+--------------------------------------------+----------
//   request  | in_valid/in_ready, req_type, key, write_data | in
//   result   | out_valid/out_ready, hit, read_data, evicted | out
//   config   | psel, penable, pwrite, paddr, pwdata, prdata, pready | apb
//
// a get, put or remove walks the probe through the cell chain one entry per cycle,
// then the result at the chain tail is captured and the update is committed before
// the next accept. a clear skips the probe and goes straight to commit. reset empties the cache at once.
// the result sits in an output register; a new item is accepted while it waits,
// but its commit holds until the previous result has been taken.
module fifo_replacement_key_value_cache #(
  parameter int ENTRIES    = ffkv_pkg::DEF_ENTRIES,
  parameter int KEY_WIDTH  = ffkv_pkg::DEF_KEY_WIDTH,
  parameter int DATA_WIDTH = ffkv_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic [ffkv_pkg::KEY_PORT_W-1:0]     key,
  input  logic [ffkv_pkg::DATA_PORT_W-1:0]    write_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic [ffkv_pkg::DATA_PORT_W-1:0]    read_data,
  output logic                                evicted,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ffkv_pkg::ADDR_W-1:0]         paddr,
  input  logic [ffkv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ffkv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import ffkv_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_t;

  state_t                state;
  logic [1:0]            req_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic                  launch;
  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      evict_ptr;
  logic [IDX_W-1:0]      insert_ptr;

  // probe result captured from the chain tail
  logic                  sc_found;
  logic [IDX_W-1:0]      sc_fidx;
  logic [DATA_WIDTH-1:0] sc_data;
  logic                  sc_ev_have;
  logic [IDX_W-1:0]      sc_eidx;
  logic                  sc_fr_have;
  logic                  sc_fr_ge;
  logic [IDX_W-1:0]      sc_fridx;

  probe_flags_t          chain_flags [ENTRIES+1];
  logic [IDX_W-1:0]      chain_fidx  [ENTRIES+1];
  logic [DATA_WIDTH-1:0] chain_data  [ENTRIES+1];
  logic [IDX_W-1:0]      chain_eidx  [ENTRIES+1];
  logic [IDX_W-1:0]      chain_fridx [ENTRIES+1];

  cell_cmd_t             cmd;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      inv_idx;

  logic                  accept;
  logic                  commit;
  logic                  cfg_wr;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic                  ev_do;
  logic                  evict_valid;
  logic                  e_ge;
  logic                  use_e;
  logic [IDX_W-1:0]      ins_slot;
  logic                  ins_new;
  logic [CNT_W-1:0]      count_next;
  logic [IDX_W-1:0]      evict_ptr_next;
  logic [IDX_W-1:0]      insert_ptr_next;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == ST_COMMIT) && (!out_valid || out_ready);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata   = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(capacity) : '0;

  always_comb begin
    chain_flags[0]        = '0;
    chain_flags[0].active = launch;
    chain_fidx[0]         = '0;
    chain_data[0]         = '0;
    chain_eidx[0]         = '0;
    chain_fridx[0]        = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ffkv_cell #(
      .ENTRIES    (ENTRIES),
      .KEY_WIDTH  (KEY_WIDTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_ID    (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .req_key        (key_q),
      .wr_data        (data_q),
      .evict_ptr      (evict_ptr),
      .insert_ptr     (insert_ptr),
      .cmd            (cmd),
      .wr_idx         (wr_idx),
      .inv_idx        (inv_idx),
      .prev_flags     (chain_flags[i]),
      .prev_found_idx (chain_fidx[i]),
      .prev_data      (chain_data[i]),
      .prev_ev_idx    (chain_eidx[i]),
      .prev_fr_idx    (chain_fridx[i]),
      .fwd_flags      (chain_flags[i+1]),
      .fwd_found_idx  (chain_fidx[i+1]),
      .fwd_data       (chain_data[i+1]),
      .fwd_ev_idx     (chain_eidx[i+1]),
      .fwd_fr_idx     (chain_fridx[i+1])
    );
  end

  // capacity above the entry count acts as the entry count
  assign cap_ext     = CMP_W'(capacity);
  assign cap_eff     = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign ev_do       = (req_q == REQ_PUT) && !sc_found && (CMP_W'(count) >= cap_eff);
  assign evict_valid = ev_do && sc_ev_have;
  // the evicted slot becomes free: take it if it comes first from insert_ptr
  assign e_ge        = sc_eidx >= insert_ptr;
  assign use_e       = evict_valid && (!sc_fr_have || (e_ge && !sc_fr_ge) ||
                                       ((e_ge == sc_fr_ge) && (sc_eidx < sc_fridx)));
  assign ins_slot    = use_e ? sc_eidx : (sc_fr_have ? sc_fridx : insert_ptr);
  assign ins_new     = use_e || sc_fr_have;

  always_comb begin
    cmd             = '0;
    wr_idx          = '0;
    inv_idx         = '0;
    count_next      = count;
    evict_ptr_next  = evict_ptr;
    insert_ptr_next = insert_ptr;
    case (req_q)
      REQ_CLEAR: begin
        cmd.clear       = commit;
        count_next      = '0;
        evict_ptr_next  = '0;
        insert_ptr_next = '0;
      end
      REQ_PUT: begin
        if (sc_found) begin
          cmd.wr = commit;
          wr_idx = sc_fidx;
        end else begin
          cmd.wr     = commit;
          cmd.wr_key = commit;
          wr_idx     = ins_slot;
          cmd.inv    = commit && evict_valid;
          inv_idx    = sc_eidx;
          count_next = count - CNT_W'(evict_valid) + CNT_W'(ins_new);
          if (evict_valid) begin
            evict_ptr_next = (sc_eidx == IDX_W'(ENTRIES - 1)) ? '0 : sc_eidx + IDX_W'(1);
          end
          insert_ptr_next = (ins_slot == IDX_W'(ENTRIES - 1)) ? '0 : ins_slot + IDX_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (sc_found) begin
          cmd.inv    = commit;
          inv_idx    = sc_fidx;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      launch     <= 1'b0;
      capacity   <= CAPACITY_RESET;
      count      <= '0;
      evict_ptr  <= '0;
      insert_ptr <= '0;
      out_valid  <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (cfg_wr) begin
        capacity <= pwdata[CAP_W-1:0];
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_q  <= req_type;
            key_q  <= key[KEY_WIDTH-1:0];
            data_q <= write_data[DATA_WIDTH-1:0];
            if (req_type == REQ_CLEAR) begin
              state <= ST_COMMIT;
            end else begin
              launch <= 1'b1;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (chain_flags[ENTRIES].active) begin
            sc_found   <= chain_flags[ENTRIES].found;
            sc_fidx    <= chain_fidx[ENTRIES];
            sc_data    <= chain_data[ENTRIES];
            sc_ev_have <= chain_flags[ENTRIES].ev_have;
            sc_eidx    <= chain_eidx[ENTRIES];
            sc_fr_have <= chain_flags[ENTRIES].fr_have;
            sc_fr_ge   <= chain_flags[ENTRIES].fr_ge;
            sc_fridx   <= chain_fridx[ENTRIES];
            state      <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit) begin
            count      <= count_next;
            evict_ptr  <= evict_ptr_next;
            insert_ptr <= insert_ptr_next;
            out_valid  <= 1'b1;
            hit        <= (req_q != REQ_CLEAR) && sc_found;
            read_data  <= ((req_q == REQ_GET) && sc_found) ? DATA_PORT_W'(sc_data) : '0;
            evicted    <= ev_do;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* dv/tb.sv */
// testbench for the fifo-replacement key/value cache: shadow cache, directed and random traffic
import ffkv_pkg::*;

typedef struct {
  logic                   hit;
  logic [DATA_PORT_W-1:0] data;
  logic                   evicted;
} kv_reply_t;

class cache_shadow;
  bit                     slot_valid[DEF_ENTRIES];
  bit [KEY_PORT_W-1:0]    slot_key[DEF_ENTRIES];
  bit [DATA_PORT_W-1:0]   slot_data[DEF_ENTRIES];
  int                     fill_count;
  int                     evict_ptr;
  int                     insert_ptr;
  int                     capacity;
  int                     errors;
  kv_reply_t              pending_replies[$];

  function new();
    foreach (slot_valid[i]) slot_valid[i] = 0;
    fill_count = 0;
    evict_ptr  = 0;
    insert_ptr = 0;
    capacity   = CAPACITY_RESET;
    errors     = 0;
  endfunction

  function void set_capacity(logic [CAP_W-1:0] value);
    capacity = value;
  endfunction

  function int pending();
    return pending_replies.size();
  endfunction

  function int find_key(logic [KEY_PORT_W-1:0] k);
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // accepted request: update the shadow state and queue the reply it must produce
  function void note_request(logic [1:0] req, logic [KEY_PORT_W-1:0] k,
                             logic [DATA_PORT_W-1:0] d);
    kv_reply_t r;
    int        idx;
    int        s;
    int        cap;
    int        slot;
    bit        done;
    r.hit     = 1'b0;
    r.data    = '0;
    r.evicted = 1'b0;
    cap = (capacity > DEF_ENTRIES) ? DEF_ENTRIES : capacity;
    if (req == REQ_CLEAR) begin
      foreach (slot_valid[i]) slot_valid[i] = 0;
      fill_count = 0;
      evict_ptr  = 0;
      insert_ptr = 0;
    end else begin
      idx = find_key(k);
      r.hit = (idx >= 0);
      if (req == REQ_GET) begin
        if (idx >= 0) r.data = slot_data[idx];
      end else if (req == REQ_REMOVE) begin
        if (idx >= 0) begin
          slot_valid[idx] = 0;
          fill_count--;
        end
      end else if (idx >= 0) begin
        slot_data[idx] = d;
      end else begin
        // new key: drop the oldest entry first when full
        if (fill_count >= cap) begin
          r.evicted = 1'b1;
          done = 0;
          for (int i = 0; i < DEF_ENTRIES && !done; i++) begin
            s = (evict_ptr + i) % DEF_ENTRIES;
            if (slot_valid[s]) begin
              slot_valid[s] = 0;
              fill_count--;
              evict_ptr = (s + 1) % DEF_ENTRIES;
              done = 1;
            end
          end
        end
        slot = insert_ptr;
        done = 0;
        for (int i = 0; i < DEF_ENTRIES && !done; i++) begin
          s = (insert_ptr + i) % DEF_ENTRIES;
          if (!slot_valid[s]) begin
            slot = s;
            done = 1;
          end
        end
        if (!slot_valid[slot]) fill_count++;
        slot_key[slot]   = k;
        slot_data[slot]  = d;
        slot_valid[slot] = 1;
        insert_ptr = (slot + 1) % DEF_ENTRIES;
      end
    end
    pending_replies.push_back(r);
  endfunction

  function void check_result(logic h, logic [DATA_PORT_W-1:0] rd, logic ev);
    kv_reply_t e;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected result: hit=%0b read_data=%h evicted=%0b",
               $time, h, rd, ev);
      errors++;
      return;
    end
    e = pending_replies.pop_front();
    if (h !== e.hit) begin
      $display("%0t: hit mismatch: expected %0b actual %0b", $time, e.hit, h);
      errors++;
    end
    if (rd !== e.data) begin
      $display("%0t: read_data mismatch: expected %h actual %h", $time, e.data, rd);
      errors++;
    end
    if (ev !== e.evicted) begin
      $display("%0t: evicted mismatch: expected %0b actual %0b", $time, e.evicted, ev);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 200;
  localparam int POOL_MAX      = 40;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             req_type;
  logic [KEY_PORT_W-1:0]  key;
  logic [DATA_PORT_W-1:0] write_data;
  logic                   out_valid;
  logic                   out_ready;
  logic                   hit;
  logic [DATA_PORT_W-1:0] read_data;
  logic                   evicted;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  cache_shadow            shadow;
  logic [KEY_PORT_W-1:0]  key_pool[POOL_MAX];
  int                     pool_size;
  bit                     tx_calm;
  bit                     rx_calm;
  bit                     long_hold_req;
  int                     rx_gap;
  int                     cycle_count;
  logic [CAP_W-1:0]       phase_caps[8];
  int                     eff_cap;

  fifo_replacement_key_value_cache dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .key        (key),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_data  (read_data),
    .evicted    (evicted),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [KEY_PORT_W-1:0] k,
                           input logic [DATA_PORT_W-1:0] d, input int gap);
    in_valid   <= 1'b1;
    req_type   <= req;
    key        <= k;
    write_data <= d;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(req, k, d);
    // valid stays up when the next item follows back to back
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.set_capacity(value);
  endtask

  task automatic fill_pool(input int n);
    for (int i = 0; i < n; i++) begin
      key_pool[i] = {$urandom, $urandom};
      // neighbors that differ in a single bit stress the key compare
      if (i % 2 == 1 && $urandom_range(0, 1) == 1)
        key_pool[i] = key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));
    end
    if ($urandom_range(0, 1) == 1) begin
      key_pool[0] = '0;
      key_pool[n-1] = '1;
    end
    pool_size = n;
  endtask

  task automatic send_random();
    logic [1:0]             req;
    logic [KEY_PORT_W-1:0]  k;
    int                     r;
    r = $urandom_range(0, 99);
    if (r < 38)      req = REQ_GET;
    else if (r < 78) req = REQ_PUT;
    else if (r < 99) req = REQ_REMOVE;
    else             req = REQ_CLEAR;
    if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
    else k = key_pool[$urandom_range(0, pool_size - 1)];
    send_item(req, k, {$urandom, $urandom}, pick_gap(tx_calm));
  endtask

  // result side: random back-pressure plus the long hold requested by the sender
  initial begin
    out_ready = 1'b0;
    rx_gap = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) shadow.check_result(hit, read_data, evicted);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_gap = LONG_HOLD;
      end else if (rx_gap == 0) begin
        rx_gap = pick_gap(rx_calm);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    shadow = new();
    long_hold_req = 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_GET;
    key        <= '0;
    write_data <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty lookups, extreme keys and data, update, remove, clear
    send_item(REQ_GET,    64'h0123_4567_89ab_cdef, '0, 0);
    send_item(REQ_REMOVE, 64'h0123_4567_89ab_cdef, '0, 1);
    send_item(REQ_PUT,    '1, '1, 0);
    send_item(REQ_PUT,    '0, '0, 0);
    send_item(REQ_GET,    '1, '0, 2);
    send_item(REQ_GET,    '0, '1, 0);
    send_item(REQ_PUT,    '1, 64'h5555_5555_aaaa_aaaa, 0);
    send_item(REQ_GET,    '1, '0, 0);
    send_item(REQ_GET,    64'h7fff_ffff_ffff_ffff, '0, 0);
    send_item(REQ_REMOVE, '0, '0, 0);
    send_item(REQ_GET,    '0, '0, 3);
    send_item(REQ_CLEAR,  '1, '1, 0);
    send_item(REQ_GET,    '1, '0, 0);
    wait_drained();

    // zero capacity: first put evicts with nothing valid, second drops the first
    write_capacity(5'd0);
    send_item(REQ_PUT,    64'h8000_0000_0000_0001, 64'hdead_beef_0000_0001, 0);
    send_item(REQ_PUT,    64'h0000_0000_0000_0002, 64'h1234_5678_9abc_def0, 0);
    send_item(REQ_GET,    64'h8000_0000_0000_0001, '0, 0);
    send_item(REQ_GET,    64'h0000_0000_0000_0002, '0, 0);
    send_item(REQ_PUT,    64'h0000_0000_0000_0002, 64'hffff_0000_ffff_0000, 0);
    send_item(REQ_GET,    64'h0000_0000_0000_0002, '0, 0);
    wait_drained();

    phase_caps[0] = 5'd31;
    phase_caps[1] = 5'd1;
    phase_caps[2] = 5'd2;
    phase_caps[3] = CAP_W'($urandom_range(3, 15));
    phase_caps[4] = 5'd16;
    phase_caps[5] = 5'd0;
    phase_caps[6] = 5'd17;
    phase_caps[7] = CAP_W'($urandom_range(0, 31));

    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      eff_cap = (phase_caps[p] > DEF_ENTRIES) ? DEF_ENTRIES : phase_caps[p];
      fill_pool((2 * eff_cap + 4 > POOL_MAX) ? POOL_MAX : 2 * eff_cap + 4);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          // switch idling style halfway so calm and busy stretches both occur
          tx_calm = !tx_calm;
          rx_calm = !rx_calm;
          if (p == 1) long_hold_req = 1'b1;
          if (p == 3) wait_drained();
        end
        send_random();
      end
      wait_drained();
    end
    rx_calm = 1'b0;

    repeat (DEF_ENTRIES + 10) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* fifo_replacement_key_value_cache.f */
rtl/ffkv_pkg.sv
rtl/ffkv_cell.sv
rtl/fifo_replacement_key_value_cache.sv
dv/tb.sv
